// ===== sv/mlfq_pkg.sv =====
// mlfq_pkg: level codes, mode and register codes, quantum reset values and the
// queue command struct shared by the scheduler top level and its queue block.
// Depends on nothing.
package mlfq_pkg;

    localparam int LEVEL_W = 2;

    localparam logic [LEVEL_W-1:0] LVL_TOP = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_MID = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_BOT = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

    localparam logic [1:0] CFG_Q_TOP = 2'd0;
    localparam logic [1:0] CFG_Q_MID = 2'd1;
    localparam logic [1:0] CFG_Q_BOT = 2'd2;

    localparam logic [7:0] Q1_TIME = 8'd1;
    localparam logic [7:0] Q2_TIME = 8'd2;
    localparam logic [7:0] Q3_TIME = 8'd4;

    typedef struct packed {
        logic               pop;
        logic [LEVEL_W-1:0] pop_lvl;
        logic               push;
        logic [LEVEL_W-1:0] push_lvl;
    } q_cmd_t;

endpackage

// ===== sv/mlfq_three_level_scheduler_top.sv =====
// mlfq_three_level_scheduler_top: three-level feedback queue scheduler with a
// process memory and a queue block. Depends on mlfq_pkg and mlfq_queues.
//
// A load item (mode 0) gives no result; busy stays low.
// A run item (mode 1) holds busy high after its transfer, through the fetch,
// execute and statistics states, so no new item is taken until it is through:
// the head index is read from the queue memory, then the process entry is read
// from the process memory at that index, then the slice is computed and written
// back, then the statistics are formed. The result appears on the output ports
// for one cycle with done high, in the cycle after the last of these. A run item
// with all queues empty gives its idle result the cycle after the transfer and
// keeps busy low. The receiver cannot stall results. Configuration writes are always ready.
module mlfq_three_level_scheduler_top
    import mlfq_pkg::*;
#(
    parameter int MAX_PROCS = 8,
    parameter int TIME_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [15:0] burst_len,
    input  logic [15:0] arrival_at,
    output logic        done,
    output logic        idle,
    output logic [2:0]  proc_index,
    output logic [1:0]  level,
    output logic [15:0] slice_start,
    output logic [15:0] slice_end,
    output logic [15:0] remaining,
    output logic        finished,
    output logic [15:0] turnaround,
    output logic [15:0] waiting,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int TW    = TIME_BITS;
    localparam int ENT_W = 3 * TW;
    localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_EXEC  = 4'b0100,
        S_STAT  = 4'b1000
    } state_t;

    function automatic logic [15:0] to_out(input logic [TW-1:0] t);
        logic [31:0] w;
        w = 32'(t);
        return w[15:0];
    endfunction

    state_t             state_reg, state_next;
    logic [TW-1:0]      time_reg;
    logic [CNT_W-1:0]   loaded_reg;
    logic [LEVEL_W-1:0] lvl_reg;
    logic [7:0]         q_top_reg, q_mid_reg, q_bot_reg;

    // process memory entry: burst, arrival, remaining
    logic [ENT_W-1:0]   pmem [MAX_PROCS];
    logic [ENT_W-1:0]   prd_reg;
    logic               pwr_en;
    logic [IDX_W-1:0]   pwr_addr;
    logic [ENT_W-1:0]   pwr_data;

    q_cmd_t             qcmd;
    logic [IDX_W-1:0]   push_idx;
    logic [IDX_W-1:0]   head_idx;
    logic [2:0]         nonempty;

    logic               accept;
    logic               load_ok;
    logic [LEVEL_W-1:0] sel_lvl;
    logic [TW-1:0]      burst_in, arrival_in;

    logic [TW-1:0]      p_burst, p_arr, p_rem;
    logic [7:0]         q_raw;
    logic [TW-1:0]      q_eff;
    logic [TW-1:0]      run_len;
    logic [TW:0]        end_sum;
    logic [TW-1:0]      end_time;
    logic [TW-1:0]      new_rem;
    logic [LEVEL_W-1:0] down_lvl;

    logic [TW-1:0]      start_reg, end_reg, rem_reg;
    logic [TW-1:0]      turn_val, wait_val;

    logic               done_reg;
    logic               idle_reg;
    logic [2:0]         idx_out_reg;
    logic [1:0]         lvl_out_reg;
    logic [15:0]        start_out_reg, end_out_reg, rem_out_reg;
    logic               fin_out_reg;
    logic [15:0]        turn_out_reg, wait_out_reg;

    mlfq_queues #(
        .MAX_PROCS (MAX_PROCS),
        .IDX_W     (IDX_W)
    ) u_queues (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (qcmd),
        .push_idx (push_idx),
        .head_idx (head_idx),
        .nonempty (nonempty)
    );

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign load_ok   = (loaded_reg < CNT_W'(MAX_PROCS));
    assign burst_in   = TW'(32'(burst_len));
    assign arrival_in = TW'(32'(arrival_at));

    always_comb
    begin
        if (nonempty[0])
        begin
            sel_lvl = LVL_TOP;
        end
        else if (nonempty[1])
        begin
            sel_lvl = LVL_MID;
        end
        else
        begin
            sel_lvl = LVL_BOT;
        end
    end

    // slice arithmetic on the fetched entry
    always_comb
    begin
        p_burst = prd_reg[3*TW-1:2*TW];
        p_arr   = prd_reg[2*TW-1:TW];
        p_rem   = prd_reg[TW-1:0];
        case (lvl_reg)
            LVL_TOP: q_raw = q_top_reg;
            LVL_MID: q_raw = q_mid_reg;
            default: q_raw = q_bot_reg;
        endcase
        if (q_raw == 8'd0)
        begin
            q_eff = TW'(1);
        end
        else
        begin
            q_eff = TW'(q_raw);
        end
        run_len = (p_rem > q_eff) ? q_eff : p_rem;
        end_sum = {1'b0, time_reg} + {1'b0, run_len};
        end_time = end_sum[TW] ? TIME_MAX : end_sum[TW-1:0];
        new_rem  = p_rem - run_len;
        down_lvl = (lvl_reg == LVL_TOP) ? LVL_MID : LVL_BOT;
    end

    always_comb
    begin
        turn_val = (end_reg > p_arr) ? end_reg - p_arr : '0;
        wait_val = (turn_val > p_burst) ? turn_val - p_burst : '0;
    end

    always_comb
    begin
        qcmd     = '0;
        push_idx = head_idx;
        pwr_en   = 1'b0;
        pwr_addr = head_idx;
        pwr_data = {p_burst, p_arr, new_rem};
        if (accept && mode == MODE_LOAD && load_ok)
        begin
            qcmd.push     = 1'b1;
            qcmd.push_lvl = LVL_TOP;
            push_idx      = IDX_W'(loaded_reg);
            pwr_en        = 1'b1;
            pwr_addr      = IDX_W'(loaded_reg);
            pwr_data      = {burst_in, arrival_in, burst_in};
        end
        else if (accept && mode == MODE_RUN && (|nonempty))
        begin
            qcmd.pop     = 1'b1;
            qcmd.pop_lvl = sel_lvl;
        end
        else if (state_reg == S_EXEC)
        begin
            pwr_en = 1'b1;
            if (new_rem != '0)
            begin
                qcmd.push     = 1'b1;
                qcmd.push_lvl = down_lvl;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && mode == MODE_RUN && (|nonempty))
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: state_next = S_EXEC;
            S_EXEC:  state_next = S_STAT;
            S_STAT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            time_reg   <= '0;
            loaded_reg <= '0;
            lvl_reg    <= LVL_TOP;
            q_top_reg  <= Q1_TIME;
            q_mid_reg  <= Q2_TIME;
            q_bot_reg  <= Q3_TIME;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (accept && mode == MODE_RUN && !(|nonempty))
                         || (state_reg == S_STAT);
            if (accept && mode == MODE_LOAD && load_ok)
            begin
                loaded_reg <= loaded_reg + 1'b1;
            end
            if (accept && mode == MODE_RUN)
            begin
                lvl_reg <= sel_lvl;
            end
            if (state_reg == S_EXEC)
            begin
                time_reg <= end_time;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_Q_TOP: q_top_reg <= cfg_data;
                    CFG_Q_MID: q_mid_reg <= cfg_data;
                    CFG_Q_BOT: q_bot_reg <= cfg_data;
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pwr_en)
        begin
            pmem[pwr_addr] <= pwr_data;
        end
        if (state_reg == S_FETCH)
        begin
            prd_reg <= pmem[head_idx];
        end
    end

    // slice values held for the statistics cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC)
        begin
            start_reg <= time_reg;
            end_reg   <= end_time;
            rem_reg   <= new_rem;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && mode == MODE_RUN && !(|nonempty))
        begin
            idle_reg      <= 1'b1;
            idx_out_reg   <= '0;
            lvl_out_reg   <= '0;
            start_out_reg <= '0;
            end_out_reg   <= '0;
            rem_out_reg   <= '0;
            fin_out_reg   <= 1'b0;
            turn_out_reg  <= '0;
            wait_out_reg  <= '0;
        end
        else if (state_reg == S_STAT)
        begin
            idle_reg      <= 1'b0;
            idx_out_reg   <= 3'(32'(head_idx));
            lvl_out_reg   <= lvl_reg;
            start_out_reg <= to_out(start_reg);
            end_out_reg   <= to_out(end_reg);
            rem_out_reg   <= to_out(rem_reg);
            fin_out_reg   <= (rem_reg == '0);
            turn_out_reg  <= (rem_reg == '0) ? to_out(turn_val) : 16'd0;
            wait_out_reg  <= (rem_reg == '0) ? to_out(wait_val) : 16'd0;
        end
    end

    assign done        = done_reg;
    assign idle        = idle_reg;
    assign proc_index  = idx_out_reg;
    assign level       = lvl_out_reg;
    assign slice_start = start_out_reg;
    assign slice_end   = end_out_reg;
    assign remaining   = rem_out_reg;
    assign finished    = fin_out_reg;
    assign turnaround  = turn_out_reg;
    assign waiting     = wait_out_reg;

endmodule

// ===== sv/mlfq_queues.sv =====
// mlfq_queues: three circular index queues held in one memory, with head and
// count registers per level and a registered head read.
// Depends on mlfq_pkg (q_cmd_t, level codes).
module mlfq_queues
    import mlfq_pkg::*;
#(
    parameter int MAX_PROCS = 8,
    parameter int IDX_W     = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  q_cmd_t           cmd,
    input  logic [IDX_W-1:0] push_idx,
    output logic [IDX_W-1:0] head_idx,
    output logic [2:0]       nonempty
);

    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int ADDR_W = $clog2(3 * MAX_PROCS);
    localparam int DEPTH  = 3 * MAX_PROCS;

    logic [IDX_W-1:0]  qmem [DEPTH];
    logic [IDX_W-1:0]  rd_reg;

    logic [IDX_W-1:0]  head_reg  [3];
    logic [IDX_W-1:0]  head_next [3];
    logic [CNT_W-1:0]  count_reg  [3];
    logic [CNT_W-1:0]  count_next [3];

    logic [IDX_W-1:0]  pop_head;
    logic [IDX_W-1:0]  push_head;
    logic [CNT_W-1:0]  push_count;
    logic [SUM_W-1:0]  tail_sum;
    logic [IDX_W-1:0]  tail_pos;
    logic [ADDR_W-1:0] pop_addr;
    logic [ADDR_W-1:0] push_addr;
    logic              push_ok;

    always_comb
    begin
        pop_head   = '0;
        push_head  = '0;
        push_count = '0;
        for (int l = 0; l < 3; l++)
        begin
            if (cmd.pop_lvl == LEVEL_W'(l))
            begin
                pop_head = head_reg[l];
            end
            if (cmd.push_lvl == LEVEL_W'(l))
            begin
                push_head  = head_reg[l];
                push_count = count_reg[l];
            end
        end
    end

    // tail position wraps around the circular queue
    always_comb
    begin
        tail_sum = SUM_W'(push_head) + SUM_W'(push_count);
        if (tail_sum >= SUM_W'(MAX_PROCS))
        begin
            tail_sum = tail_sum - SUM_W'(MAX_PROCS);
        end
        tail_pos  = IDX_W'(tail_sum);
        push_ok   = cmd.push && (push_count < CNT_W'(MAX_PROCS));
        pop_addr  = ADDR_W'(cmd.pop_lvl) * ADDR_W'(MAX_PROCS) + ADDR_W'(pop_head);
        push_addr = ADDR_W'(cmd.push_lvl) * ADDR_W'(MAX_PROCS) + ADDR_W'(tail_pos);
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            head_next[l]  = head_reg[l];
            count_next[l] = count_reg[l];
            if (cmd.pop && cmd.pop_lvl == LEVEL_W'(l))
            begin
                if (head_reg[l] == IDX_W'(MAX_PROCS - 1))
                begin
                    head_next[l] = '0;
                end
                else
                begin
                    head_next[l] = head_reg[l] + 1'b1;
                end
                count_next[l] = count_next[l] - 1'b1;
            end
            if (push_ok && cmd.push_lvl == LEVEL_W'(l))
            begin
                count_next[l] = count_next[l] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < 3; l++)
            begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end
        else
        begin
            for (int l = 0; l < 3; l++)
            begin
                head_reg[l]  <= head_next[l];
                count_reg[l] <= count_next[l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            qmem[push_addr] <= push_idx;
        end
        if (cmd.pop)
        begin
            rd_reg <= qmem[pop_addr];
        end
    end

    assign head_idx = rd_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            nonempty[l] = (count_reg[l] != '0);
        end
    end

endmodule

// ===== tb/mlfq_three_level_scheduler_top_tb.sv =====
// mlfq_three_level_scheduler_top_tb: self-checking bench for the three-level feedback queue
// scheduler; predicts every slice result and compares it field by field with the block.
// Depends on mlfq_pkg and mlfq_three_level_scheduler_top.
module mlfq_three_level_scheduler_top_tb;
    import mlfq_pkg::*;

    localparam int MAX_PROCS     = 8;
    localparam int TIME_MAX      = 65535;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 16;
    localparam int STALL_LIMIT   = 1000;

    typedef enum logic [1:0] {CMD_ITEM, CMD_REG, CMD_DRAIN} cmd_kind_t;

    typedef struct {
        cmd_kind_t   kind;
        logic        op;
        logic [15:0] burst;
        logic [15:0] arrival;
        logic [1:0]  reg_idx;
        logic [7:0]  reg_val;
        bit          steady;
    } sched_cmd_t;

    typedef struct packed {
        logic        idle;
        logic [2:0]  proc_index;
        logic [1:0]  level;
        logic [15:0] slice_start;
        logic [15:0] slice_end;
        logic [15:0] remaining;
        logic        finished;
        logic [15:0] turnaround;
        logic [15:0] waiting;
    } slice_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    logic        mode         = MODE_LOAD;
    logic [15:0] burst_len    = '0;
    logic [15:0] arrival_at   = '0;
    logic        cfg_valid    = 1'b0;
    logic [1:0]  cfg_index    = CFG_Q_TOP;
    logic [7:0]  cfg_data     = '0;
    logic        busy;
    logic        done;
    logic        idle;
    logic [2:0]  proc_index;
    logic [1:0]  level;
    logic [15:0] slice_start;
    logic [15:0] slice_end;
    logic [15:0] remaining;
    logic        finished;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic        cfg_ready;

    sched_cmd_t  sched_cmds [$];
    slice_t      slices_due [$];
    int          mismatches   = 0;
    int          stall_cycles = 0;
    int          gap_left     = 0;
    int          settle       = 0;

    // scheduler state as predicted
    logic [15:0] left_tbl   [MAX_PROCS];
    logic [15:0] burst_tbl  [MAX_PROCS];
    logic [15:0] arrive_tbl [MAX_PROCS];
    logic [2:0]  ready_fifo [3][MAX_PROCS];
    int          fifo_head  [3];
    int          fifo_cnt   [3];
    logic [15:0] sched_now;
    int          procs_loaded;
    logic [7:0]  quantum    [3];

    mlfq_three_level_scheduler_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .burst_len    (burst_len),
        .arrival_at   (arrival_at),
        .done         (done),
        .idle         (idle),
        .proc_index   (proc_index),
        .level        (level),
        .slice_start  (slice_start),
        .slice_end    (slice_end),
        .remaining    (remaining),
        .finished     (finished),
        .turnaround   (turnaround),
        .waiting      (waiting),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void enqueue(input int lv, input logic [2:0] idx);
        ready_fifo[lv][(fifo_head[lv] + fifo_cnt[lv]) % MAX_PROCS] = idx;
        fifo_cnt[lv]++;
    endfunction

    // one scheduling slice: pick the highest non-empty level, run, demote or retire
    function automatic slice_t next_slice();
        slice_t     r;
        int         lv;
        int         q;
        logic [2:0] idx;
        int         ran;
        int         fin;
        int         spent;
        int         slack;
        r  = '0;
        lv = -1;
        for (int k = int'(LVL_TOP); k <= int'(LVL_BOT); k++)
        begin
            if (lv < 0 && fifo_cnt[k] != 0)
                lv = k;
        end
        if (lv < 0)
        begin
            r.idle = 1'b1;
            return r;
        end
        idx           = ready_fifo[lv][fifo_head[lv]];
        fifo_head[lv] = (fifo_head[lv] + 1) % MAX_PROCS;
        fifo_cnt[lv]--;
        q   = (quantum[lv] == 8'd0) ? 1 : int'(quantum[lv]);
        ran = (int'(left_tbl[idx]) > q) ? q : int'(left_tbl[idx]);
        fin = int'(sched_now) + ran;
        if (fin > TIME_MAX)
            fin = TIME_MAX;
        r.proc_index  = idx;
        r.level       = lv[1:0];
        r.slice_start = sched_now;
        r.slice_end   = fin[15:0];
        sched_now     = fin[15:0];
        left_tbl[idx] = left_tbl[idx] - ran[15:0];
        r.remaining   = left_tbl[idx];
        if (left_tbl[idx] == 16'd0)
        begin
            spent        = (fin > int'(arrive_tbl[idx])) ? fin - int'(arrive_tbl[idx]) : 0;
            slack        = (spent > int'(burst_tbl[idx])) ? spent - int'(burst_tbl[idx]) : 0;
            r.finished   = 1'b1;
            r.turnaround = spent[15:0];
            r.waiting    = slack[15:0];
        end
        else
        begin
            // bottom level is round robin
            enqueue((lv == int'(LVL_BOT)) ? int'(LVL_BOT) : lv + 1, idx);
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic add_item(input logic op, input logic [15:0] burst,
                            input logic [15:0] arrival, input bit steady);
        sched_cmd_t c;
        c = '{CMD_ITEM, op, burst, arrival, CFG_Q_TOP, 8'd0, steady};
        sched_cmds.push_back(c);
    endtask

    task automatic add_phase(input logic [7:0] q_top, input logic [7:0] q_mid,
                             input logic [7:0] q_bot);
        sched_cmds.push_back('{CMD_REG, MODE_LOAD, 16'd0, 16'd0, CFG_Q_TOP, q_top, 1'b0});
        sched_cmds.push_back('{CMD_REG, MODE_LOAD, 16'd0, 16'd0, CFG_Q_MID, q_mid, 1'b0});
        sched_cmds.push_back('{CMD_REG, MODE_LOAD, 16'd0, 16'd0, CFG_Q_BOT, q_bot, 1'b0});
    endtask

    // mostly run items; loads here hit a full table, drains hold the sender off
    task automatic add_random_runs(input int runs, input int calm_tail);
        int pick;
        int issued;
        issued = 0;
        while (issued < runs)
        begin
            pick = $urandom_range(0, 99);
            if (issued >= runs - calm_tail)
            begin
                add_item(MODE_RUN, 16'($urandom), 16'($urandom), 1'b1);
                issued++;
            end
            else if (pick < 8)
                add_item(MODE_LOAD, 16'($urandom), 16'($urandom), 1'b0);
            else if (pick < 10)
                sched_cmds.push_back('{CMD_DRAIN, MODE_RUN, 16'd0, 16'd0, CFG_Q_TOP, 8'd0,
                                       1'b0});
            else
            begin
                add_item(MODE_RUN, 16'($urandom), 16'($urandom), 1'b0);
                issued++;
            end
        end
    endtask

    // driver: one item per transfer, random sender gaps, register writes only when quiet
    always @(posedge clk or negedge rst_n)
    begin : drive
        sched_cmd_t c;
        logic       took;
        logic       nxt_start;
        logic       nxt_cfg;
        if (!rst_n)
        begin
            start        <= 1'b0;
            cfg_valid    <= 1'b0;
            mode         <= MODE_LOAD;
            burst_len    <= '0;
            arrival_at   <= '0;
            cfg_index    <= CFG_Q_TOP;
            cfg_data     <= '0;
            gap_left      = 0;
            settle        = 0;
        end
        else
        begin
            took      = start && !busy;
            nxt_start = start && !took;
            nxt_cfg   = cfg_valid && !cfg_ready;
            if (!nxt_start && !nxt_cfg)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (sched_cmds.size() != 0)
                begin
                    c = sched_cmds[0];
                    if (c.kind == CMD_ITEM)
                    begin
                        void'(sched_cmds.pop_front());
                        nxt_start     = 1'b1;
                        mode         <= c.op;
                        burst_len    <= c.burst;
                        arrival_at   <= c.arrival;
                        if (!c.steady && $urandom_range(0, 4) == 0)
                            gap_left = $urandom_range(1, 4);
                    end
                    else if (slices_due.size() != 0 || cfg_valid)
                        settle = 0;
                    else if (settle < SETTLE_CYCLES)
                        settle++;
                    else
                    begin
                        settle = 0;
                        void'(sched_cmds.pop_front());
                        if (c.kind == CMD_REG)
                        begin
                            nxt_cfg    = 1'b1;
                            cfg_index <= c.reg_idx;
                            cfg_data  <= c.reg_val;
                        end
                    end
                end
            end
            start     <= nxt_start;
            cfg_valid <= nxt_cfg;
        end
    end

    // monitor: checks each result, then folds this edge's transfers into the prediction
    always @(posedge clk or negedge rst_n)
    begin : watch
        slice_t want;
        slice_t got;
        if (!rst_n)
        begin
            slices_due.delete();
            for (int k = int'(LVL_TOP); k <= int'(LVL_BOT); k++)
            begin
                fifo_head[k] = 0;
                fifo_cnt[k]  = 0;
            end
            sched_now       = '0;
            procs_loaded    = 0;
            quantum[LVL_TOP] = Q1_TIME;
            quantum[LVL_MID] = Q2_TIME;
            quantum[LVL_BOT] = Q3_TIME;
        end
        else
        begin
            if (done)
            begin
                got = {idle, proc_index, level, slice_start, slice_end, remaining,
                       finished, turnaround, waiting};
                if (slices_due.size() == 0)
                begin
                    $display("%0t: result expected none, got idle %0d proc_index %0d",
                             $time, got.idle, got.proc_index);
                    mismatches++;
                end
                else
                begin
                    want = slices_due.pop_front();
                    check_field("idle",        want.idle,        got.idle);
                    check_field("proc_index",  want.proc_index,  got.proc_index);
                    check_field("level",       want.level,       got.level);
                    check_field("slice_start", want.slice_start, got.slice_start);
                    check_field("slice_end",   want.slice_end,   got.slice_end);
                    check_field("remaining",   want.remaining,   got.remaining);
                    check_field("finished",    want.finished,    got.finished);
                    check_field("turnaround",  want.turnaround,  got.turnaround);
                    check_field("waiting",     want.waiting,     got.waiting);
                end
            end
            if (start && !busy)
            begin
                if (mode == MODE_RUN)
                    slices_due.push_back(next_slice());
                else if (procs_loaded < MAX_PROCS)
                begin
                    burst_tbl[procs_loaded]  = burst_len;
                    arrive_tbl[procs_loaded] = arrival_at;
                    left_tbl[procs_loaded]   = burst_len;
                    enqueue(int'(LVL_TOP), procs_loaded[2:0]);
                    procs_loaded++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_Q_TOP: quantum[LVL_TOP] = cfg_data;
                    CFG_Q_MID: quantum[LVL_MID] = cfg_data;
                    CFG_Q_BOT: quantum[LVL_BOT] = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        // empty queues give an idle slice
        add_item(MODE_RUN, 16'd0, 16'd0, 1'b0);
        // zero burst, arrival after the end time, short burst that reaches the bottom
        add_item(MODE_LOAD, 16'd0, 16'd0, 1'b0);
        add_item(MODE_LOAD, 16'd3, 16'hFFFF, 1'b0);
        add_item(MODE_LOAD, 16'd5, 16'd2, 1'b0);
        repeat (7)
            add_item(MODE_RUN, 16'd0, 16'd0, 1'b0);
        // long process drives the clock into saturation later on
        add_item(MODE_LOAD, 16'hFFFF, 16'd0, 1'b0);
        repeat (4)
            add_item(MODE_LOAD, 16'($urandom_range(1, 3000)), 16'($urandom_range(0, 400)), 1'b0);
        // table is full now, this load is dropped
        add_item(MODE_LOAD, 16'h1234, 16'h4321, 1'b0);
        repeat (5)
            add_item(MODE_RUN, 16'd0, 16'd0, 1'b0);

        add_phase(8'd0, 8'd0, 8'd0);
        add_random_runs(60, 0);
        add_phase(8'd255, 8'd255, 8'd255);
        add_random_runs(200, 0);
        add_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                  8'($urandom_range(1, 255)));
        add_random_runs(100, 0);
        add_phase(8'd1, 8'd128, 8'd255);
        add_random_runs(220, 100);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (sched_cmds.size() != 0 || start || cfg_valid || slices_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
